@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the cache tag model.
// No dependencies; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, switched off while reset is low.
`define SALC_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) else $error(msg);

// Same, on the block's own clk and arst_n.
`define SALC_ASSERT_LOCAL(lbl, prop, msg) \
	`SALC_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

@@ src/salc_pkg.sv @@
// Package of the set-associative LRU cache tag model: shared types and
// constants. No dependencies.
package salc_pkg;

	localparam int ADDR_PORT_W     = 64;
	localparam int CNT_W           = 32;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 6;
	localparam int SET_BITS_W      = 4;
	localparam int OFFSET_BITS_W   = 6;
	localparam int WAYS_W          = 4;
	localparam int MAX_OFFSET_BITS = 32;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_SET_INDEX_BITS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE       = 2'd2;

	// Register values after reset
	localparam logic [SET_BITS_W-1:0]    RST_SET_INDEX_BITS    = 4'd4;
	localparam logic [OFFSET_BITS_W-1:0] RST_BLOCK_OFFSET_BITS = 6'd4;
	localparam logic [WAYS_W-1:0]        RST_WAYS_IN_USE       = 4'd8;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_LOOKUP
	} salc_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture; // take the address, read the set
		logic update;  // decide hit or victim, write the set back
	} salc_cmd_t;

	// Raw configuration registers
	typedef struct packed {
		logic [SET_BITS_W-1:0]    set_index_bits;
		logic [OFFSET_BITS_W-1:0] block_offset_bits;
		logic [WAYS_W-1:0]        ways_in_use;
	} salc_cfg_t;

endpackage

@@ src/salc_ctrl.sv @@
// Controller of the cache tag model: two-state sequencer that issues the
// capture and update commands. Depends on salc_pkg.
module salc_ctrl
	import salc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output salc_cmd_t cmd
);

	salc_state_t state_q;
	salc_state_t state_d;
	logic        done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.update  = 1'b0;
		case (state_q)
			ST_IDLE: cmd.capture = start;
			ST_LOOKUP: begin
				busy       = 1'b1;
				cmd.update = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.update;
		end
	end

	assign done = done_q;

endmodule

@@ src/salc_datapath.sv @@
// Datapath of the cache tag model: address split, set memories, hit and
// victim choice, recency update and saturating totals. Depends on salc_pkg.
module salc_datapath
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS  = 8,
	parameter int NUM_WAYS      = 8,
	parameter int ADDRESS_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  salc_cmd_t              cmd,
	input  salc_cfg_t              cfg,
	input  logic [ADDR_PORT_W-1:0] address,
	output logic                   hit,
	output logic                   evicted,
	output logic [CNT_W-1:0]       hit_total,
	output logic [CNT_W-1:0]       miss_total,
	output logic [CNT_W-1:0]       eviction_total
);

	localparam int SETS     = 1 << MAX_SET_BITS;
	localparam int TAG_W    = ADDRESS_WIDTH - 2;
	localparam int RANK_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
	localparam int NW_W     = $clog2(NUM_WAYS + 1);
	localparam int SH_W     = OFFSET_BITS_W + 1;
	localparam int RANK_MAX = NUM_WAYS - 1;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// Clamped configuration
	logic [SB_W-1:0]          sb_c;
	logic [OFFSET_BITS_W-1:0] ob_c;
	logic [NW_W-1:0]          nw_c;
	logic [SH_W-1:0]          tag_shift;

	always_comb begin
		if (cfg.set_index_bits == '0) sb_c = SB_W'(1);
		else if (cfg.set_index_bits > MAX_SET_BITS) sb_c = SB_W'(MAX_SET_BITS);
		else sb_c = SB_W'(cfg.set_index_bits);

		if (cfg.block_offset_bits == '0) ob_c = OFFSET_BITS_W'(1);
		else if (cfg.block_offset_bits > MAX_OFFSET_BITS)
			ob_c = OFFSET_BITS_W'(MAX_OFFSET_BITS);
		else ob_c = cfg.block_offset_bits;

		if (cfg.ways_in_use == '0) nw_c = NW_W'(1);
		else if (cfg.ways_in_use > NUM_WAYS) nw_c = NW_W'(NUM_WAYS);
		else nw_c = NW_W'(cfg.ways_in_use);

		tag_shift = SH_W'(sb_c) + SH_W'(ob_c);
	end

	// Address split at capture
	logic [ADDRESS_WIDTH-1:0] addr_m;
	logic [ADDRESS_WIDTH-1:0] addr_sh_set;
	logic [ADDRESS_WIDTH-1:0] addr_sh_tag;
	logic [MAX_SET_BITS-1:0]  set_mask;
	logic [MAX_SET_BITS-1:0]  set_cap;
	logic [TAG_W-1:0]         tag_cap;

	always_comb begin
		addr_m      = address[ADDRESS_WIDTH-1:0];
		addr_sh_set = addr_m >> ob_c;
		addr_sh_tag = addr_m >> tag_shift;
		set_mask    = ~({MAX_SET_BITS{1'b1}} << sb_c);
		set_cap     = addr_sh_set[MAX_SET_BITS-1:0] & set_mask;
		tag_cap     = addr_sh_tag[TAG_W-1:0];
	end

	// Set memories, one row per set
	logic [NUM_WAYS-1:0]              mem_valid [SETS];
	logic [NUM_WAYS-1:0][RANK_W-1:0]  mem_rank  [SETS];
	logic [NUM_WAYS-1:0][TAG_W-1:0]   mem_tag   [SETS];
	logic [SETS-1:0]                  row_ok_q;

	logic [MAX_SET_BITS-1:0]          set_s1;
	logic [TAG_W-1:0]                 tag_s1;
	logic                             row_ok_s1;
	logic [NUM_WAYS-1:0]              valid_rd_s1;
	logic [NUM_WAYS-1:0][RANK_W-1:0]  rank_rd_s1;
	logic [NUM_WAYS-1:0][TAG_W-1:0]   tag_rd_s1;

	logic [NUM_WAYS-1:0]              valid_new;
	logic [NUM_WAYS-1:0][RANK_W-1:0]  rank_new;
	logic [NUM_WAYS-1:0][TAG_W-1:0]   tag_new;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem_valid[set_s1] <= valid_new;
			mem_rank[set_s1]  <= rank_new;
			mem_tag[set_s1]   <= tag_new;
		end
		if (cmd.capture) begin
			valid_rd_s1 <= mem_valid[set_cap];
			rank_rd_s1  <= mem_rank[set_cap];
			tag_rd_s1   <= mem_tag[set_cap];
			row_ok_s1   <= row_ok_q[set_cap];
			set_s1      <= set_cap;
			tag_s1      <= tag_cap;
		end
	end

	// A row never written since reset reads as all invalid, rank zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
		end else if (cmd.update) begin
			row_ok_q[set_s1] <= 1'b1;
		end
	end

	// Lookup and victim choice
	logic [NUM_WAYS-1:0]             valid_eff;
	logic [NUM_WAYS-1:0][RANK_W-1:0] rank_eff;
	logic                            hit_found;
	logic [WAY_W-1:0]                hit_way;
	logic                            inv_found;
	logic [WAY_W-1:0]                inv_way;
	logic [WAY_W-1:0]                lru_way;
	logic [RANK_W-1:0]               lru_rank;
	logic [WAY_W-1:0]                sel_way;
	logic [RANK_W:0]                 old_rank;
	logic                            evict;

	always_comb begin
		valid_eff = row_ok_s1 ? valid_rd_s1 : '0;
		rank_eff  = row_ok_s1 ? rank_rd_s1 : '0;
		hit_found = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		lru_way   = '0;
		lru_rank  = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (w < nw_c) begin
				if (!hit_found && valid_eff[w] && tag_rd_s1[w] == tag_s1) begin
					hit_found = 1'b1;
					hit_way   = WAY_W'(w);
				end
				if (!inv_found && !valid_eff[w]) begin
					inv_found = 1'b1;
					inv_way   = WAY_W'(w);
				end
				if (w == 0 || rank_eff[w] > lru_rank) begin
					lru_rank = rank_eff[w];
					lru_way  = WAY_W'(w);
				end
			end
		end

		evict = 1'b0;
		if (hit_found) begin
			sel_way  = hit_way;
			old_rank = {1'b0, rank_eff[hit_way]};
		end else if (inv_found) begin
			sel_way  = inv_way;
			old_rank = (RANK_W + 1)'(NUM_WAYS);
		end else begin
			sel_way  = lru_way;
			old_rank = {1'b0, lru_rank};
			evict    = 1'b1;
		end

		// Age every valid line younger than the one brought to the front
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (WAY_W'(i) == sel_way) begin
				rank_new[i] = '0;
			end else if (valid_eff[i] && {1'b0, rank_eff[i]} < old_rank &&
			             {1'b0, rank_eff[i]} < (RANK_W + 1)'(RANK_MAX)) begin
				rank_new[i] = rank_eff[i] + 1'b1;
			end else begin
				rank_new[i] = rank_eff[i];
			end
		end

		valid_new          = valid_eff;
		valid_new[sel_way] = 1'b1;
		tag_new            = tag_rd_s1;
		tag_new[sel_way]   = tag_s1;
	end

	// Result and totals
	logic             hit_q;
	logic             evicted_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] evict_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q     <= hit_found;
			evicted_q <= evict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (cmd.update) begin
			if (hit_found) begin
				hit_cnt_q <= sat_inc(hit_cnt_q);
			end else begin
				miss_cnt_q <= sat_inc(miss_cnt_q);
				if (evict) evict_cnt_q <= sat_inc(evict_cnt_q);
			end
		end
	end

	assign hit            = hit_q;
	assign evicted        = evicted_q;
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_cnt_q;
	assign eviction_total = evict_cnt_q;

endmodule

@@ src/set_assoc_lru_cache_model_core.sv @@
// Top level of the set-associative LRU cache tag model: configuration
// registers, controller and datapath. Depends on salc_pkg, salc_ctrl,
// salc_datapath and assert_macros.svh.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  access    | start / busy            | address
//  result    | done (one-cycle strobe) | hit, evicted, hit_total, miss_total,
//            |                         | eviction_total
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// The set row is read from the tag, valid and recency memories at the
// accepting edge and decided and written back in the next cycle; busy is
// high while it is written back, so a following access always reads the row
// already written back. The result strobe is registered from the write-back
// and overlaps the next access. Reset clears the totals and one row-valid
// flop per set and loads the reset configuration, so no clearing pass is
// needed. The receiver cannot stall; cfg_ready is always high.
`include "assert_macros.svh"

module set_assoc_lru_cache_model_core
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS  = 8,
	parameter int NUM_WAYS      = 8,
	parameter int ADDRESS_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [ADDR_PORT_W-1:0] address,
	output logic                   done,
	output logic                   hit,
	output logic                   evicted,
	output logic [CNT_W-1:0]       hit_total,
	output logic [CNT_W-1:0]       miss_total,
	output logic [CNT_W-1:0]       eviction_total,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	salc_cfg_t cfg_q;
	salc_cmd_t cmd;

	// Configuration is always taken; an unknown index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_index_bits    <= RST_SET_INDEX_BITS;
			cfg_q.block_offset_bits <= RST_BLOCK_OFFSET_BITS;
			cfg_q.ways_in_use       <= RST_WAYS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SET_INDEX_BITS:    cfg_q.set_index_bits    <= cfg_data[SET_BITS_W-1:0];
				REG_BLOCK_OFFSET_BITS: cfg_q.block_offset_bits <= cfg_data;
				REG_WAYS_IN_USE:       cfg_q.ways_in_use       <= cfg_data[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequence each transaction: capture, then update
	salc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Split the address, look up the set, write it back, keep the totals
	salc_datapath #(
		.MAX_SET_BITS  (MAX_SET_BITS),
		.NUM_WAYS      (NUM_WAYS),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg_q),
		.address        (address),
		.hit            (hit),
		.evicted        (evicted),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

	// An accepted access holds busy for exactly one cycle
	`SALC_ASSERT_LOCAL(a_accept_busy, (start && !busy) |=> busy, "busy did not follow an accepted access")
	`SALC_ASSERT_LOCAL(a_busy_single, busy |=> !busy, "busy held for more than one cycle")
	// A result follows the write-back cycle and nothing else
	`SALC_ASSERT_LOCAL(a_done_after_busy, done |-> $past(busy), "result strobe without a preceding lookup")
	// A hit never replaces a line
	`SALC_ASSERT_LOCAL(a_hit_no_evict, done |-> !(hit && evicted), "hit reported together with an eviction")

endmodule

@@ tb/set_assoc_lru_cache_model_core_tb.sv @@
// Testbench for set_assoc_lru_cache_model_core: a directed burst, then random access phases
// under changing cache geometries, all checked against an in-bench LRU tag-store predictor.
// Depends on salc_pkg and the core RTL only.
module set_assoc_lru_cache_model_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import salc_pkg::*;

	localparam int SET_TOTAL   = 256; // 2^MAX_SET_BITS
	localparam int WAY_TOTAL   = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 73;

	// No register sits at this index; writes to it must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evictions;
	} lookup_outcome_t;

	// Shadow tag store: tracks valid, tag and recency age per line, plus the
	// running totals, and queues the outcome each accepted access must give.
	class lru_lookup_tracker;
		bit                     way_valid [SET_TOTAL][WAY_TOTAL];
		bit [63:0]              way_tag   [SET_TOTAL][WAY_TOTAL];
		bit [2:0]               way_age   [SET_TOTAL][WAY_TOTAL];
		bit [SET_BITS_W-1:0]    set_bits_reg;
		bit [OFFSET_BITS_W-1:0] offset_bits_reg;
		bit [WAYS_W-1:0]        ways_reg;
		bit [CNT_W-1:0]         hit_tally, miss_tally, evict_tally;
		lookup_outcome_t        pending[$];
		int unsigned            mismatches;

		function new();
			set_bits_reg    = RST_SET_INDEX_BITS;
			offset_bits_reg = RST_BLOCK_OFFSET_BITS;
			ways_reg        = RST_WAYS_IN_USE;
			foreach (way_valid[s, w]) begin
				way_valid[s][w] = 1'b0;
				way_tag[s][w]   = '0;
				way_age[s][w]   = '0;
			end
			hit_tally   = '0;
			miss_tally  = '0;
			evict_tally = '0;
			mismatches  = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_SET_INDEX_BITS:    set_bits_reg    = data[SET_BITS_W-1:0];
				REG_BLOCK_OFFSET_BITS: offset_bits_reg = data[OFFSET_BITS_W-1:0];
				REG_WAYS_IN_USE:       ways_reg        = data[WAYS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_set_bits();
			if (set_bits_reg == 0) return 1;
			return (set_bits_reg > 8) ? 8 : set_bits_reg;
		endfunction

		function int unsigned eff_offset_bits();
			if (offset_bits_reg == 0) return 1;
			return (offset_bits_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_reg;
		endfunction

		function int unsigned eff_ways();
			if (ways_reg == 0) return 1;
			return (ways_reg > WAY_TOTAL) ? WAY_TOTAL : ways_reg;
		endfunction

		function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		// Make way w the newest; age every valid line that was newer than it.
		function void promote(int s, int w, int older_than);
			for (int i = 0; i < WAY_TOTAL; i++)
				if (i != w && way_valid[s][i] && way_age[s][i] < older_than &&
						way_age[s][i] < WAY_TOTAL - 1)
					way_age[s][i]++;
			way_age[s][w] = '0;
		endfunction

		function void note_access(bit [63:0] addr);
			int unsigned     sb, ob, nw, s, victim, oldest;
			bit [63:0]       tag;
			bit              found_free;
			lookup_outcome_t exp;
			sb = eff_set_bits();
			ob = eff_offset_bits();
			nw = eff_ways();
			tag = addr >> (sb + ob);
			s = int'((addr >> ob) & ((64'd1 << sb) - 1));
			exp = '0;
			for (int w = 0; w < nw; w++)
				if (way_valid[s][w] && way_tag[s][w] == tag) begin
					hit_tally = bump(hit_tally);
					promote(s, w, way_age[s][w]);
					exp.hit       = 1'b1;
					exp.hits      = hit_tally;
					exp.misses    = miss_tally;
					exp.evictions = evict_tally;
					pending.push_back(exp);
					return;
				end
			miss_tally = bump(miss_tally);
			found_free = 1'b0;
			victim = 0;
			for (int w = 0; w < nw; w++)
				if (!found_free && !way_valid[s][w]) begin
					victim = w;
					found_free = 1'b1;
				end
			if (found_free) begin
				promote(s, victim, WAY_TOTAL);
			end else begin
				oldest = way_age[s][0];
				for (int w = 1; w < nw; w++)
					if (way_age[s][w] > oldest) begin
						oldest = way_age[s][w];
						victim = w;
					end
				evict_tally = bump(evict_tally);
				exp.evicted = 1'b1;
				promote(s, victim, way_age[s][victim]);
			end
			way_valid[s][victim] = 1'b1;
			way_tag[s][victim]   = tag;
			exp.hits      = hit_tally;
			exp.misses    = miss_tally;
			exp.evictions = evict_tally;
			pending.push_back(exp);
		endfunction

		function void check_outcome(lookup_outcome_t seen);
			lookup_outcome_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with nothing outstanding: hit=%0b evicted=%0b", $realtime,
						seen.hit, seen.evicted);
				return;
			end
			exp = pending.pop_front();
			if (seen !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] mismatch: expected hit=%0b evicted=%0b totals=%0d/%0d/%0d",
						$realtime, exp.hit, exp.evicted, exp.hits, exp.misses, exp.evictions);
					$display("[%0t] mismatch: got hit=%0b evicted=%0b totals=%0d/%0d/%0d",
						$realtime, seen.hit, seen.evicted, seen.hits, seen.misses, seen.evictions);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [ADDR_PORT_W-1:0] address;
	logic                   done;
	logic                   hit;
	logic                   evicted;
	logic [CNT_W-1:0]       hit_total;
	logic [CNT_W-1:0]       miss_total;
	logic [CNT_W-1:0]       eviction_total;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	lru_lookup_tracker tracker = new();
	int unsigned       cycle_count = 0;

	set_assoc_lru_cache_model_core #(
		.MAX_SET_BITS (8),
		.NUM_WAYS     (WAY_TOTAL),
		.ADDRESS_WIDTH(64)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.address       (address),
		.done          (done),
		.hit           (hit),
		.evicted       (evicted),
		.hit_total     (hit_total),
		.miss_total    (miss_total),
		.eviction_total(eviction_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock, starting low so the first falling edge comes after a full period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run if the transactions never drain.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: the strobe lasts one cycle and cannot be held off, so take
	// every strobed result at the edge that ends its cycle.
	always @(posedge clk) begin : result_monitor
		lookup_outcome_t seen;
		if (arst_n === 1'b1 && done === 1'b1) begin
			seen.hit       = hit;
			seen.evicted   = evicted;
			seen.hits      = hit_total;
			seen.misses    = miss_total;
			seen.evictions = eviction_total;
			tracker.check_outcome(seen);
		end
	end

	// Present one access from the falling edge and hold it until an edge sees
	// start high with busy low. start is left high so the next access can follow
	// straight on; callers lower it when they idle or drain.
	task automatic issue_access(input bit [63:0] addr);
		@(negedge clk);
		start   <= 1'b1;
		address <= addr;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_access(addr);
	endtask

	// Drop start for a burst of idle cycles.
	task automatic hold_off(input int unsigned cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and hold until every accepted access has reported back. Each
	// access yields exactly one result, so an empty queue means the core is idle.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending.size() != 0) @(negedge clk);
	endtask

	// One configuration transaction; only issued while the core is idle.
	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		tracker.write_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Build an address from tag, set and byte offset under the current geometry.
	// High tag bits that do not fit above the shift simply fall off.
	function automatic bit [63:0] compose(bit [63:0] tag, bit [63:0] set_no, bit [63:0] offs);
		int unsigned sb, ob;
		sb = tracker.eff_set_bits();
		ob = tracker.eff_offset_bits();
		return (tag << (sb + ob)) | ((set_no & ((64'd1 << sb) - 1)) << ob) |
			(offs & ((64'd1 << ob) - 1));
	endfunction

	// Directed burst under the reset geometry (16 sets, 16-byte blocks, 8 ways):
	// address extremes, a repeat hit, then one set overfilled so the oldest line
	// is replaced, a hit refreshes a line and the next miss takes the new oldest.
	task automatic run_directed();
		issue_access(64'd0);
		issue_access('1);
		issue_access(64'd0);
		issue_access(64'h8000_0000_0000_0000);
		issue_access(64'hAAAA_AAAA_AAAA_AAAA);
		issue_access(64'h5555_5555_5555_5555);
		for (int t = 1; t <= 9; t++)
			issue_access(compose(64'(t), 64'd3, 64'(t)));
		issue_access(compose(64'd2, 64'd3, 64'd0));
		issue_access(compose(64'd1, 64'd3, 64'hF));
		issue_access(compose(64'd2, 64'd3, 64'd7));
	endtask

	// Phase geometry. Even phases set the whole geometry (low clamps, top of
	// range, over-range clamps, then random); odd phases only move the way count,
	// so lines beyond a lowered count must sit untouched until it rises again.
	task automatic configure_phase(input int p);
		wait_drained();
		case (p)
			0: begin
				write_cfg(REG_SET_INDEX_BITS, 6'd0);
				write_cfg(REG_BLOCK_OFFSET_BITS, 6'd0);
				write_cfg(REG_WAYS_IN_USE, 6'd0);
				write_cfg(REG_UNUSED, 6'd63);
			end
			2: begin
				write_cfg(REG_SET_INDEX_BITS, 6'd8);
				write_cfg(REG_BLOCK_OFFSET_BITS, 6'd32);
				write_cfg(REG_WAYS_IN_USE, 6'd8);
			end
			4: begin
				write_cfg(REG_SET_INDEX_BITS, 6'd63);
				write_cfg(REG_BLOCK_OFFSET_BITS, 6'd63);
				write_cfg(REG_WAYS_IN_USE, 6'd63);
				write_cfg(REG_UNUSED, 6'd0);
			end
			default: begin
				if (p % 2 == 1) begin
					write_cfg(REG_WAYS_IN_USE, 6'($urandom_range(0, 63)));
				end else begin
					write_cfg(REG_SET_INDEX_BITS, 6'($urandom_range(0, 63)));
					write_cfg(REG_BLOCK_OFFSET_BITS, 6'($urandom_range(0, 63)));
					write_cfg(REG_WAYS_IN_USE, 6'($urandom_range(0, 63)));
					if ($urandom_range(0, 1) == 1)
						write_cfg(REG_UNUSED, 6'($urandom));
				end
			end
		endcase
	endtask

	// Random accesses. Most hit a few hot sets with tags from a pool slightly
	// larger than the way count, which keeps the sets full and churning; the
	// rest scatter pool tags across all sets or are raw random addresses.
	task automatic run_phase(input int p, input int unsigned count, input bit idle_on);
		bit [63:0]   tag_pool[$];
		bit [63:0]   hot_sets[3];
		bit [63:0]   tag;
		int unsigned pick;
		for (int i = 0; i < tracker.eff_ways() + 2; i++)
			tag_pool.push_back(($urandom_range(0, 1) == 1) ? 64'($urandom_range(0, 15)) :
				{$urandom, $urandom});
		foreach (hot_sets[i])
			hot_sets[i] = 64'($urandom);
		for (int unsigned n = 0; n < count; n++) begin
			// In phase 3 only, hold off once mid-phase until every outstanding result is back.
			if (p == 3 && n == count / 2)
				wait_drained();
			if (idle_on && $urandom_range(0, 9) == 0)
				hold_off($urandom_range(1, 17));
			pick = $urandom_range(0, 99);
			tag  = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
			if (pick < 80)
				issue_access(compose(tag, hot_sets[$urandom_range(0, 2)], {$urandom, $urandom}));
			else if (pick < 90)
				issue_access(compose(tag, 64'($urandom), {$urandom, $urandom}));
			else
				issue_access({$urandom, $urandom});
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		address   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		// The last two phases run with no idling at all.
		for (int p = 0; p < PHASES; p++) begin
			configure_phase(p);
			run_phase(p, PHASE_ITEMS, p < PHASES - 2);
		end

		wait_drained();
		// Allow for a stray late strobe.
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
